[design/http_chunked_body_decoder_defines.svh]
// Assertion macros shared by the chunked body decoder RTL.
// Each macro takes a label, an antecedent and a consequent; clk and rst_n
// of the including module are sampled.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CHDEC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chdec assertion failed");

// Next-cycle implication
`define CHDEC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chdec assertion failed");

`else

`define CHDEC_ASSERT_IMP(label, ante, cons)
`define CHDEC_ASSERT_NXT(label, ante, cons)

`endif

`endif

[design/chdec_pkg.sv]
package chdec_pkg;

  // Width of the size accumulator and remaining-byte counter
  localparam int SIZE_BITS = 30;
  // Width of the max chunk size register
  localparam int CFG_W = 30;
  localparam logic [CFG_W-1:0] MAX_CHUNK_RESET = CFG_W'(32'h2000_0000);

  // Decoder phase, one-hot
  typedef enum logic [5:0] {
    PH_SIZE    = 6'b000001,
    PH_EXT     = 6'b000010,
    PH_DATA    = 6'b000100,
    PH_TERM    = 6'b001000,
    PH_TRAILER = 6'b010000,
    PH_IDLE    = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ERR_SIZE_LINE = 2'd0,
    ERR_TOO_LARGE = 2'd1,
    ERR_TERM      = 2'd2,
    ERR_TRUNC     = 2'd3
  } err_code_t;

  typedef struct packed {
    phase_t                phase;
    logic [SIZE_BITS-1:0]  size_accum;
    logic [SIZE_BITS-1:0]  bytes_left;
    logic                  hex_seen;
    logic                  cr_pending;
    logic                  line_text;
    logic                  error_hold;
  } chdec_state_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic       message_done;
    logic       error_flag;
    err_code_t  error_code;
  } chdec_res_t;

  localparam chdec_state_t STATE_RESET = '{
    phase:      PH_SIZE,
    size_accum: '0,
    bytes_left: '0,
    hex_seen:   1'b0,
    cr_pending: 1'b0,
    line_text:  1'b0,
    error_hold: 1'b0
  };

endpackage

[design/chdec_cfg.sv]
module chdec_cfg import chdec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CFG_W-1:0] max_chunk_size
);

  logic [CFG_W-1:0] max_r;
  logic [CFG_W-1:0] max_nxt;
  logic             sel_max;

  // Only register 0 exists; the upper word is a hole
  assign sel_max = (paddr[2] == 1'b0);

  always_comb begin
    max_nxt = max_r;
    if (psel && penable && pwrite && sel_max) begin
      max_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_CHUNK_RESET;
    end else begin
      max_r <= max_nxt;
    end
  end

  assign pready         = 1'b1;
  assign prdata         = sel_max ? {{(32-CFG_W){1'b0}}, max_r} : 32'd0;
  assign max_chunk_size = max_r;

endmodule

[design/chdec_step.sv]
module chdec_step import chdec_pkg::*; (
  input  chdec_state_t     st,
  input  logic [7:0]       data_byte,
  input  logic             stream_end,
  input  logic             restart,
  input  logic [CFG_W-1:0] max_chunk_size,
  output chdec_state_t     st_nxt,
  output chdec_res_t       res
);

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // Hex digit value, 16 for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
    return v;
  endfunction

  phase_t               ph;
  chdec_state_t         eol_st;
  chdec_res_t           eol_res;
  chdec_res_t           zero_res;
  logic [4:0]           digit;
  logic                 accum_full;
  logic                 is_cr;
  logic                 is_lf;
  logic [SIZE_BITS-1:0] left_dec;

  assign ph         = (st.phase == PH_IDLE) ? PH_SIZE : st.phase;
  assign digit      = hex_value(data_byte);
  assign accum_full = |st.size_accum[SIZE_BITS-1 -: 4];
  assign is_cr      = (data_byte == CH_CR);
  assign is_lf      = (data_byte == CH_LF);
  assign left_dec   = st.bytes_left - SIZE_BITS'(1);

  assign zero_res = '{body_byte: 8'd0, body_valid: 1'b0, message_done: 1'b0,
                      error_flag: 1'b0, error_code: ERR_SIZE_LINE};

  // Outcome of a size line closed by CRLF
  always_comb begin
    eol_st            = st;
    eol_st.phase      = ph;
    eol_res           = zero_res;
    eol_st.cr_pending = 1'b0;
    if (!st.hex_seen) begin
      eol_st.error_hold  = 1'b1;
      eol_res.error_flag = 1'b1;
      eol_res.error_code = ERR_SIZE_LINE;
    end else if (st.size_accum > max_chunk_size) begin
      eol_st.error_hold  = 1'b1;
      eol_res.error_flag = 1'b1;
      eol_res.error_code = ERR_TOO_LARGE;
    end else if (st.size_accum == '0) begin
      eol_st.phase     = PH_TRAILER;
      eol_st.line_text = 1'b0;
    end else begin
      eol_st.bytes_left = st.size_accum;
      eol_st.phase      = PH_DATA;
    end
    eol_st.size_accum = '0;
    eol_st.hex_seen   = 1'b0;
  end

  // Per-byte state update
  always_comb begin
    st_nxt = st;
    res    = zero_res;
    if (restart) begin
      st_nxt = STATE_RESET;
    end else if (st.error_hold) begin
      st_nxt = st;
    end else if (stream_end) begin
      if (st.phase != PH_IDLE) begin
        st_nxt.error_hold = 1'b1;
        res.error_flag    = 1'b1;
        res.error_code    = ERR_TRUNC;
      end
    end else begin
      st_nxt.phase = ph;
      case (ph)
        PH_EXT: begin
          if (st.cr_pending && is_lf) begin
            st_nxt = eol_st;
            res    = eol_res;
          end else begin
            st_nxt.cr_pending = is_cr;
          end
        end
        PH_DATA: begin
          res.body_byte     = data_byte;
          res.body_valid    = 1'b1;
          st_nxt.bytes_left = left_dec;
          if (left_dec == '0) st_nxt.phase = PH_TERM;
        end
        PH_TERM: begin
          if (!st.cr_pending && is_cr) begin
            st_nxt.cr_pending = 1'b1;
          end else if (st.cr_pending && is_lf) begin
            st_nxt.cr_pending = 1'b0;
            st_nxt.phase      = PH_SIZE;
          end else begin
            st_nxt.error_hold = 1'b1;
            res.error_flag    = 1'b1;
            res.error_code    = ERR_TERM;
          end
        end
        PH_TRAILER: begin
          if (st.cr_pending && is_lf) begin
            st_nxt.cr_pending = 1'b0;
            st_nxt.line_text  = 1'b0;
            if (!st.line_text) begin
              res.message_done = 1'b1;
              st_nxt.phase     = PH_IDLE;
            end
          end else begin
            // a lone CR counts as line text
            st_nxt.cr_pending = is_cr;
            st_nxt.line_text  = st.line_text | st.cr_pending | !is_cr;
          end
        end
        default: begin
          // size line, also after done and for unknown codes
          if (st.cr_pending) begin
            if (is_lf) begin
              st_nxt = eol_st;
              res    = eol_res;
            end else begin
              st_nxt.error_hold = 1'b1;
              res.error_flag    = 1'b1;
              res.error_code    = ERR_SIZE_LINE;
            end
          end else if (is_cr) begin
            st_nxt.cr_pending = 1'b1;
          end else if (data_byte == CH_SEMI) begin
            if (!st.hex_seen) begin
              st_nxt.error_hold = 1'b1;
              res.error_flag    = 1'b1;
              res.error_code    = ERR_SIZE_LINE;
            end else begin
              st_nxt.phase = PH_EXT;
            end
          end else if (digit[4]) begin
            st_nxt.error_hold = 1'b1;
            res.error_flag    = 1'b1;
            res.error_code    = ERR_SIZE_LINE;
          end else if (accum_full) begin
            st_nxt.error_hold = 1'b1;
            res.error_flag    = 1'b1;
            res.error_code    = ERR_TOO_LARGE;
          end else begin
            st_nxt.size_accum = {st.size_accum[SIZE_BITS-5:0], digit[3:0]};
            st_nxt.hex_seen   = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

[design/http_chunked_body_decoder.sv]
// HTTP/1.1 chunked body decoder.
// Input channel (in_valid / in_stall): one request per body byte, or a
// stream-end or restart marker (restart wins, neither carries a byte).
// Output channel (out_valid / out_stall): exactly one result per request,
// in order: a payload byte with body_valid, a message_done pulse on the
// final empty trailer line, or an error flag with its code.
// Each request passes the input register, then decode and the result
// register. Throughput: one request per cycle while out_stall is low; the
// state update between the two registers is combinational.
// When out_stall is high with a result waiting, the result register holds;
// the input register still takes one more request, then in_stall rises
// until the result drains.
// Configuration: APB register 0 (max_chunk_size) at address 0, pready
// always high; write it only while the decoder is idle.
// Reset (rst_n low, synchronous): both registers empty, decoder waits for
// a size line, max_chunk_size returns to 512 MiB. After an error every
// request but restart yields an all-zero result.
module http_chunked_body_decoder import chdec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  input  logic        in_restart,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_body_byte,
  output logic        out_body_valid,
  output logic        out_message_done,
  output logic        out_error_flag,
  output logic [1:0]  out_error_code,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "http_chunked_body_decoder_defines.svh"

  logic [CFG_W-1:0] max_chunk_size;

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_data_r;
  logic             s1_end_r;
  logic             s1_restart_r;

  chdec_state_t     st_r, st_nxt;
  chdec_res_t       res;
  chdec_res_t       res_r;
  logic             out_valid_r, out_valid_nxt;
  logic             in_take;
  logic             advance;

  chdec_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .max_chunk_size (max_chunk_size)
  );

  chdec_step u_step (
    .st             (st_r),
    .data_byte      (s1_data_r),
    .stream_end     (s1_end_r),
    .restart        (s1_restart_r),
    .max_chunk_size (max_chunk_size),
    .st_nxt         (st_nxt),
    .res            (res)
  );

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) st_r <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r    <= in_data_byte;
      s1_end_r     <= in_stream_end;
      s1_restart_r <= in_restart;
    end
    if (advance) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_body_byte    = res_r.body_byte;
  assign out_body_valid   = res_r.body_valid;
  assign out_message_done = res_r.message_done;
  assign out_error_flag   = res_r.error_flag;
  assign out_error_code   = res_r.error_code;

  `CHDEC_ASSERT_IMP(a_stall_only_full, in_stall, s1_valid_r)
  `CHDEC_ASSERT_IMP(a_byte_not_error, out_valid_r && res_r.body_valid,
                    !res_r.error_flag && !res_r.message_done)
  `CHDEC_ASSERT_IMP(a_code_needs_flag, out_valid_r && !res_r.error_flag,
                    res_r.error_code == ERR_SIZE_LINE)
  `CHDEC_ASSERT_NXT(a_error_held, advance && res.error_flag, st_r.error_hold)
  `CHDEC_ASSERT_NXT(a_done_goes_idle, advance && res.message_done,
                    st_r.phase == PH_IDLE)

endmodule
